// ----- rtl/bce_pkg.sv -----
package bce_pkg;

  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  localparam int MinSize  = 3;
  localparam int RstSize  = 1024;

  // bit order of one column in the window and the line buffer word
  localparam int ColTop = 0;
  localparam int ColMid = 1;
  localparam int ColCur = 2;

  typedef struct packed {
    logic pix;
    logic interior;
    logic frame_end;
  } item_t;

endpackage

// ----- rtl/binary_cross_erosion_top.sv -----
// The pixel that completes a window is registered in stage 1; its result then goes to the output register.
// Throughput: one pixel per cycle while out_stall_i is low; the line buffer RAM is read for each accepted pixel.
// The buffer entry read for a pixel is forwarded from the write of the one before it when both use one address.
// Reset clears the counters, the window and the pipeline; sizes return to 1024, capped at MAX_WIDTH/MAX_HEIGHT.
// Line buffer contents are undefined after reset and need no clearing.
module binary_cross_erosion_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bce_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         pixel_on_i,
  input  logic                         start_of_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         eroded_on_o,
  output logic                         frame_done_o
);

  import bce_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RstW = (RstSize > MAX_WIDTH) ? MAX_WIDTH : RstSize;
  localparam int RstH = (RstSize > MAX_HEIGHT) ? MAX_HEIGHT : RstSize;

  logic [CW-1:0] width_last_q;
  logic [RW-1:0] height_last_q;
  logic [31:0]   cfg_val;

  always_comb begin
    cfg_val = 32'(cfg_wdata_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= CW'(RstW - 1);
      height_last_q <= RW'(RstH - 1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth: begin
          if (cfg_val < 32'(MinSize)) begin
            width_last_q <= CW'(MinSize - 1);
          end else if (cfg_val > 32'(MAX_WIDTH)) begin
            width_last_q <= CW'(MAX_WIDTH - 1);
          end else begin
            width_last_q <= CW'(cfg_val - 32'd1);
          end
        end
        RegImageHeight: begin
          if (cfg_val < 32'(MinSize)) begin
            height_last_q <= RW'(MinSize - 1);
          end else if (cfg_val > 32'(MAX_HEIGHT)) begin
            height_last_q <= RW'(MAX_HEIGHT - 1);
          end else begin
            height_last_q <= RW'(cfg_val - 32'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q;
  logic out_free, s1_fire, in_accept;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // position counters, stage 0
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic          line_end, frame_end;

  always_comb begin
    col_cur   = start_of_frame_i ? '0 : col_q;
    row_cur   = start_of_frame_i ? '0 : row_q;
    line_end  = col_cur >= width_last_q;
    frame_end = line_end && (row_cur >= height_last_q);
    col_d     = line_end ? '0 : col_cur + CW'(1);
    if (!line_end) begin
      row_d = row_cur;
    end else if (frame_end) begin
      row_d = '0;
    end else begin
      row_d = row_cur + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1
  item_t         s1_q;
  logic [CW-1:0] s1_addr_q;
  logic          fwd_q;
  logic [1:0]    fwd_data_q;
  logic [1:0]    ram_rdata, line_word, wr_word;
  logic [2:0]    cur_col;
  logic [5:0]    window_q;
  logic          eroded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && (s1_addr_q == col_cur);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.pix       <= pixel_on_i;
      s1_q.interior  <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      s1_q.frame_end <= frame_end;
      s1_addr_q      <= col_cur;
      fwd_data_q     <= wr_word;
    end
  end

  bce_ram #(
    .Width (2),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_word),
    .re_i    (in_accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // word bit 0 = older line, bit 1 = newer line
  always_comb begin
    line_word = fwd_q ? fwd_data_q : ram_rdata;
    cur_col   = {s1_q.pix, line_word[1], line_word[0]};
    wr_word   = {s1_q.pix, line_word[1]};
    eroded    = window_q[ColTop] & window_q[ColMid] & window_q[ColCur]
              & window_q[3 + ColMid] & cur_col[ColMid];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (s1_fire) begin
      window_q <= {window_q[2:0], cur_col};
    end
  end

  // output register
  logic out_valid_q, eroded_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.interior) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.interior) begin
      eroded_q <= eroded;
      done_q   <= s1_q.frame_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign eroded_on_o  = eroded_q;
  assign frame_done_o = done_q;

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted pixel did not reach stage 1");

  a_window_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(window_q))
    else $error("window changed without a pixel leaving stage 1");

  a_result_offered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.interior) |=> out_valid_o)
    else $error("interior pixel gave no result");

  a_fwd_only_after_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s1_fire) |=> !fwd_q)
    else $error("forwarding set without a concurrent write");

endmodule

// ----- rtl/bce_ram.sv -----
module bce_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old entry when written in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
